// ===== rtl/wlqe_pkg.sv =====
// Shared types and constants for the wide line quad expander.
// Used by every module in rtl/; depends on nothing.
package wlqe_pkg;

  localparam int CoordW    = 24;
  localparam int ColorW    = 32;
  localparam int WidthW    = 16;
  localparam int DiffW     = CoordW + 1;
  localparam int SqW       = 2 * DiffW;
  localparam int RadW      = 64;
  localparam int RootW     = RadW / 2;
  localparam int NumW      = WidthW + DiffW + 7;
  localparam int DivW      = NumW + 2;
  localparam int QuotW     = WidthW;
  localparam int OffW      = QuotW + 2;
  localparam int SqStages  = RootW / 2;
  localparam int DivStages = QuotW / 2;

  typedef enum logic [2:0] {
    VTX_A  = 3'd0,
    VTX_B  = 3'd1,
    VTX_C  = 3'd2,
    VTX_D  = 3'd3,
    VTX_C2 = 3'd4,
    VTX_A2 = 3'd5
  } vtx_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic signed [CoordW-1:0] x2;
    logic signed [CoordW-1:0] y2;
    logic [ColorW-1:0]        c1;
    logic [ColorW-1:0]        c2;
    logic                     fin;
  } seg_t;

  typedef struct packed {
    seg_t            seg;
    logic [NumW-1:0] num_x;
    logic [NumW-1:0] num_y;
    logic            neg_x;
    logic            neg_y;
    logic            zero;
  } meas_t;

  typedef struct packed {
    seg_t                   seg;
    logic signed [OffW-1:0] off_x;
    logic signed [OffW-1:0] off_y;
  } quad_t;

endpackage

// ===== rtl/wlqe_front.sv =====
// Front stages: endpoint differences, squares and offset numerators.
// Depends on wlqe_pkg.
module wlqe_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  wlqe_pkg::seg_t                in_seg,
  input  logic [wlqe_pkg::WidthW-1:0]   line_width,
  output logic                          out_v,
  output wlqe_pkg::meas_t               out_meas,
  output logic [wlqe_pkg::RadW-1:0]     out_rad
);
  import wlqe_pkg::*;

  logic [2:0]              v_r;
  seg_t                    seg1_r, seg2_r, seg3_r;
  logic signed [DiffW-1:0] dx1_r, dy1_r;
  logic [DiffW-1:0]        ax, ay;
  logic [SqW-1:0]          sqx2_r, sqy2_r;
  logic [WidthW+DiffW-1:0] wx2_r, wy2_r;
  logic                    negx2_r, negy2_r, zero2_r;
  logic [RadW-1:0]         rad3_r;
  meas_t                   meas3_r;
  logic [SqW-1:0]          sqsum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_v};
    end
  end

  assign ax = dx1_r[DiffW-1] ? DiffW'(-dx1_r) : DiffW'(dx1_r);
  assign ay = dy1_r[DiffW-1] ? DiffW'(-dy1_r) : DiffW'(dy1_r);
  assign sqsum = sqx2_r + sqy2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      seg1_r  <= in_seg;
      dx1_r   <= DiffW'(in_seg.x2) - DiffW'(in_seg.x1);
      dy1_r   <= DiffW'(in_seg.y2) - DiffW'(in_seg.y1);
      seg2_r  <= seg1_r;
      sqx2_r  <= SqW'(ax) * SqW'(ax);
      sqy2_r  <= SqW'(ay) * SqW'(ay);
      wx2_r   <= (WidthW+DiffW)'(line_width) * (WidthW+DiffW)'(ax);
      wy2_r   <= (WidthW+DiffW)'(line_width) * (WidthW+DiffW)'(ay);
      negx2_r <= !dy1_r[DiffW-1] && (dy1_r != '0);
      negy2_r <= dx1_r[DiffW-1];
      zero2_r <= (dx1_r == '0) && (dy1_r == '0);
      seg3_r  <= seg2_r;
      rad3_r  <= {sqsum, 14'b0};
      meas3_r <= '{seg: seg2_r, num_x: {wy2_r, 7'b0}, num_y: {wx2_r, 7'b0},
                   neg_x: negx2_r, neg_y: negy2_r, zero: zero2_r};
    end
  end

  assign out_v    = v_r[2];
  assign out_meas = meas3_r;
  assign out_rad  = rad3_r;

endmodule

// ===== rtl/wlqe_isqrt.sv =====
// Pipelined integer square root, two root bits per stage.
// Carries the segment measurements alongside. Depends on wlqe_pkg.
module wlqe_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  wlqe_pkg::meas_t             in_meas,
  input  logic [wlqe_pkg::RadW-1:0]   in_rad,
  output logic                        out_v,
  output wlqe_pkg::meas_t             out_meas,
  output logic [wlqe_pkg::RootW-1:0]  out_root
);
  import wlqe_pkg::*;

  logic [RadW-1:0]  rem_a  [0:SqStages];
  logic [RootW-1:0] root_a [0:SqStages];
  meas_t            meas_a [0:SqStages];
  logic [SqStages:0] v_a;

  assign rem_a[0]  = in_rad;
  assign root_a[0] = '0;
  assign meas_a[0] = in_meas;
  assign v_a[0]    = in_v;

  for (genvar s = 0; s < SqStages; s++) begin : g_stage
    localparam int K0 = RootW - 1 - 2 * s;
    localparam int K1 = K0 - 1;
    logic [RadW:0]    t0, t1;
    logic [RadW-1:0]  rem_m, rem_n;
    logic [RootW-1:0] root_m, root_n;
    logic             ge0, ge1;
    logic [RadW-1:0]  rem_r;
    logic [RootW-1:0] root_r;
    meas_t            meas_r;
    logic             v_r;

    always_comb begin
      t0     = ({(RadW+1-RootW)'(0), root_a[s]} << (K0 + 1)) | ((RadW+1)'(1) << (2 * K0));
      ge0    = {1'b0, rem_a[s]} >= t0;
      rem_m  = ge0 ? rem_a[s] - t0[RadW-1:0] : rem_a[s];
      root_m = root_a[s];
      if (ge0) begin
        root_m[K0] = 1'b1;
      end
      t1     = ({(RadW+1-RootW)'(0), root_m} << (K1 + 1)) | ((RadW+1)'(1) << (2 * K1));
      ge1    = {1'b0, rem_m} >= t1;
      rem_n  = ge1 ? rem_m - t1[RadW-1:0] : rem_m;
      root_n = root_m;
      if (ge1) begin
        root_n[K1] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_a[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_n;
        root_r <= root_n;
        meas_r <= meas_a[s];
      end
    end

    assign rem_a[s+1]  = rem_r;
    assign root_a[s+1] = root_r;
    assign meas_a[s+1] = meas_r;
    assign v_a[s+1]    = v_r;
  end

  assign out_v    = v_a[SqStages];
  assign out_meas = meas_a[SqStages];
  assign out_root = root_a[SqStages];

endmodule

// ===== rtl/wlqe_div.sv =====
// Pipelined rounding divider for both offset components, two quotient bits
// per stage, then sign and zero-length handling. Depends on wlqe_pkg.
module wlqe_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  wlqe_pkg::meas_t             in_meas,
  input  logic [wlqe_pkg::RootW-1:0]  in_root,
  output logic                        out_v,
  output wlqe_pkg::quad_t             out_quad
);
  import wlqe_pkg::*;

  logic [DivW-1:0]    remx_a [0:DivStages];
  logic [DivW-1:0]    remy_a [0:DivStages];
  logic [QuotW-1:0]   qx_a   [0:DivStages];
  logic [QuotW-1:0]   qy_a   [0:DivStages];
  logic [RootW:0]     den_a  [0:DivStages];
  meas_t              meas_a [0:DivStages];
  logic [DivStages:0] v_a;

  logic [DivW-1:0] nx0_r, ny0_r;
  logic [RootW:0]  den0_r;
  meas_t           meas0_r;
  logic            v0_r;
  logic            vf_r;
  quad_t           quad_r;
  logic signed [OffW-1:0] offx, offy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      vf_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_v;
      vf_r <= v_a[DivStages];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx0_r   <= {in_meas.num_x, 1'b0} + DivW'(in_root);
      ny0_r   <= {in_meas.num_y, 1'b0} + DivW'(in_root);
      den0_r  <= {in_root, 1'b0};
      meas0_r <= in_meas;
    end
  end

  assign remx_a[0] = nx0_r;
  assign remy_a[0] = ny0_r;
  assign qx_a[0]   = '0;
  assign qy_a[0]   = '0;
  assign den_a[0]  = den0_r;
  assign meas_a[0] = meas0_r;
  assign v_a[0]    = v0_r;

  for (genvar j = 0; j < DivStages; j++) begin : g_stage
    localparam int I0 = QuotW - 1 - 2 * j;
    localparam int I1 = I0 - 1;
    logic [DivW-1:0]  d0, d1, rxm, rym, rxn, ryn;
    logic [QuotW-1:0] qxn, qyn;
    logic [DivW-1:0]  remx_r, remy_r;
    logic [QuotW-1:0] qx_r, qy_r;
    logic [RootW:0]   den_r;
    meas_t            meas_r;
    logic             v_r;

    always_comb begin
      d0  = DivW'(den_a[j]) << I0;
      d1  = DivW'(den_a[j]) << I1;
      qxn = qx_a[j];
      qyn = qy_a[j];
      rxm = remx_a[j];
      rym = remy_a[j];
      if (rxm >= d0) begin
        rxm     = rxm - d0;
        qxn[I0] = 1'b1;
      end
      if (rym >= d0) begin
        rym     = rym - d0;
        qyn[I0] = 1'b1;
      end
      rxn = rxm;
      ryn = rym;
      if (rxn >= d1) begin
        rxn     = rxn - d1;
        qxn[I1] = 1'b1;
      end
      if (ryn >= d1) begin
        ryn     = ryn - d1;
        qyn[I1] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_a[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        remx_r <= rxn;
        remy_r <= ryn;
        qx_r   <= qxn;
        qy_r   <= qyn;
        den_r  <= den_a[j];
        meas_r <= meas_a[j];
      end
    end

    assign remx_a[j+1] = remx_r;
    assign remy_a[j+1] = remy_r;
    assign qx_a[j+1]   = qx_r;
    assign qy_a[j+1]   = qy_r;
    assign den_a[j+1]  = den_r;
    assign meas_a[j+1] = meas_r;
    assign v_a[j+1]    = v_r;
  end

  always_comb begin
    offx = OffW'(qx_a[DivStages]);
    offy = OffW'(qy_a[DivStages]);
    if (meas_a[DivStages].neg_x) begin
      offx = -offx;
    end
    if (meas_a[DivStages].neg_y) begin
      offy = -offy;
    end
    if (meas_a[DivStages].zero) begin
      offx = '0;
      offy = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad_r <= '{seg: meas_a[DivStages].seg, off_x: offx, off_y: offy};
    end
  end

  assign out_v    = vf_r;
  assign out_quad = quad_r;

endmodule

// ===== rtl/wlqe_expand.sv =====
// Vertex sequencer: holds one finished segment and emits its six vertices
// through a saturating adder into the output register. Depends on wlqe_pkg.
module wlqe_expand (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_v,
  input  wlqe_pkg::quad_t                   in_quad,
  output logic                              take,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [wlqe_pkg::CoordW-1:0] out_vert_x,
  output logic signed [wlqe_pkg::CoordW-1:0] out_vert_y,
  output logic                              out_tex_u,
  output logic [1:0]                        out_tex_v,
  output logic [wlqe_pkg::ColorW-1:0]       out_vert_color,
  output logic                              out_last_of_segment,
  output logic                              out_end_of_batch
);
  import wlqe_pkg::*;

  localparam logic signed [DiffW-1:0] SatMax = DiffW'((1 << (CoordW - 1)) - 1);
  localparam logic signed [DiffW-1:0] SatMin = -DiffW'(1 << (CoordW - 1));

  quad_t                    held_r;
  logic                     held_v_r;
  vtx_t                     cnt_r, cnt_nxt;
  logic                     out_valid_r;
  logic signed [CoordW-1:0] x_r, y_r;
  logic                     u_r, last_r, batch_r;
  logic [1:0]               v_r;
  logic [ColorW-1:0]        color_r;

  logic                     out_load, emit, minus, at_end;
  logic signed [CoordW-1:0] bx, by;
  logic signed [DiffW-1:0]  sx, sy, ox, oy;
  logic signed [CoordW-1:0] qx, qy;

  assign out_load = !out_valid_r || !out_stall;
  assign emit     = out_load && held_v_r;
  assign at_end   = (cnt_r == VTX_A2);
  assign take     = !held_v_r || (emit && at_end);

  always_comb begin
    minus = 1'b0;
    bx    = held_r.seg.x1;
    by    = held_r.seg.y1;
    unique case (cnt_r)
      VTX_A, VTX_A2: begin
        minus = 1'b0;
      end
      VTX_B: begin
        minus = 1'b1;
      end
      VTX_C, VTX_C2: begin
        minus = 1'b1;
        bx    = held_r.seg.x2;
        by    = held_r.seg.y2;
      end
      VTX_D: begin
        bx = held_r.seg.x2;
        by = held_r.seg.y2;
      end
      default: begin
        minus = 1'b0;
      end
    endcase
    ox = DiffW'(held_r.off_x);
    oy = DiffW'(held_r.off_y);
    sx = minus ? DiffW'(bx) - ox : DiffW'(bx) + ox;
    sy = minus ? DiffW'(by) - oy : DiffW'(by) + oy;
    qx = (sx > SatMax) ? SatMax[CoordW-1:0] : (sx < SatMin) ? SatMin[CoordW-1:0]
       : sx[CoordW-1:0];
    qy = (sy > SatMax) ? SatMax[CoordW-1:0] : (sy < SatMin) ? SatMin[CoordW-1:0]
       : sy[CoordW-1:0];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (take) begin
      cnt_nxt = VTX_A;
    end else if (emit) begin
      cnt_nxt = vtx_t'(cnt_r + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r    <= 1'b0;
      cnt_r       <= VTX_A;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (take) begin
        held_v_r <= in_v;
      end
      if (out_load) begin
        out_valid_r <= held_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_r <= in_quad;
    end
    if (emit) begin
      x_r     <= qx;
      y_r     <= qy;
      u_r     <= (cnt_r == VTX_C) || (cnt_r == VTX_D) || (cnt_r == VTX_C2);
      v_r     <= minus ? 2'd2 : 2'd0;
      color_r <= ((cnt_r == VTX_C) || (cnt_r == VTX_D) || (cnt_r == VTX_C2))
                 ? held_r.seg.c2 : held_r.seg.c1;
      last_r  <= at_end;
      batch_r <= at_end && held_r.seg.fin;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_vert_x          = x_r;
  assign out_vert_y          = y_r;
  assign out_tex_u           = u_r;
  assign out_tex_v           = v_r;
  assign out_vert_color      = color_r;
  assign out_last_of_segment = last_r;
  assign out_end_of_batch    = batch_r;

endmodule

// ===== rtl/wide_line_quad_expander.sv =====
// Wide line quad expander: turns each line segment request into six vertices.
// Each input request carries two Q15.8 endpoints, two colors and a batch flag.
// The block offsets both endpoints along the unit perpendicular scaled by
// line_width and emits A, B, C, D, C, A (two triangles) on the output channel.
// Input and output use valid/stall; a request moves when valid is high and
// stall is low. line_width sits at APB byte address 0 (reset 256); software
// must write it only while the block is idle; the block does not enforce
// it; pready is always high. From input request to first vertex the path runs
// through the 3 front stages, the 16 square-root stages and the 10 divider
// stages. Throughput is bounded by the single output port, which carries six
// vertices per segment. A new segment is taken every cycle while the pipeline
// has room, so requests stack in the stages behind the sequencer.
// Reset (synchronous, rst_n low) empties all stages and the output register.
// On a receiver stall the output register holds its vertex; once the sequencer
// and last divider stage are full, the pipeline freezes and in_stall rises.
// Depends on wlqe_pkg, wlqe_front, wlqe_isqrt, wlqe_div, wlqe_expand.
module wide_line_quad_expander (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [wlqe_pkg::CoordW-1:0] in_start_x,
  input  logic signed [wlqe_pkg::CoordW-1:0] in_start_y,
  input  logic signed [wlqe_pkg::CoordW-1:0] in_end_x,
  input  logic signed [wlqe_pkg::CoordW-1:0] in_end_y,
  input  logic [wlqe_pkg::ColorW-1:0]        in_start_color,
  input  logic [wlqe_pkg::ColorW-1:0]        in_end_color,
  input  logic                               in_final_segment,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [wlqe_pkg::CoordW-1:0] out_vert_x,
  output logic signed [wlqe_pkg::CoordW-1:0] out_vert_y,
  output logic                               out_tex_u,
  output logic [1:0]                         out_tex_v,
  output logic [wlqe_pkg::ColorW-1:0]        out_vert_color,
  output logic                               out_last_of_segment,
  output logic                               out_end_of_batch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [2:0]                         cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import wlqe_pkg::*;

  localparam logic [WidthW-1:0] WidthReset = WidthW'(256);

  logic [WidthW-1:0] line_width_r;
  logic              en, take, fr_v, sq_v, dv_v;
  seg_t              seg_in;
  meas_t             fr_meas, sq_meas;
  logic [RadW-1:0]   fr_rad;
  logic [RootW-1:0]  sq_root;
  quad_t             dv_quad;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {16'b0, line_width_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= WidthReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0) begin
      line_width_r <= cfg_pwdata[WidthW-1:0];
    end
  end

  assign en       = take || !dv_v;
  assign in_stall = !en;

  assign seg_in = '{x1: in_start_x, y1: in_start_y, x2: in_end_x, y2: in_end_y,
                    c1: in_start_color, c2: in_end_color, fin: in_final_segment};

  wlqe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_v       (in_valid),
    .in_seg     (seg_in),
    .line_width (line_width_r),
    .out_v      (fr_v),
    .out_meas   (fr_meas),
    .out_rad    (fr_rad)
  );

  wlqe_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (fr_v),
    .in_meas  (fr_meas),
    .in_rad   (fr_rad),
    .out_v    (sq_v),
    .out_meas (sq_meas),
    .out_root (sq_root)
  );

  wlqe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (sq_v),
    .in_meas  (sq_meas),
    .in_root  (sq_root),
    .out_v    (dv_v),
    .out_quad (dv_quad)
  );

  wlqe_expand u_expand (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_v                (dv_v),
    .in_quad             (dv_quad),
    .take                (take),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_vert_x          (out_vert_x),
    .out_vert_y          (out_vert_y),
    .out_tex_u           (out_tex_u),
    .out_tex_v           (out_tex_v),
    .out_vert_color      (out_vert_color),
    .out_last_of_segment (out_last_of_segment),
    .out_end_of_batch    (out_end_of_batch)
  );

endmodule

// ===== rtl/wlqe_checker.sv =====
// Port-level checks for the wide line quad expander output channel.
// Depends on wlqe_pkg; bound to wide_line_quad_expander below.
module wlqe_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [wlqe_pkg::CoordW-1:0] out_vert_x,
  input logic                               out_tex_u,
  input logic [1:0]                         out_tex_v,
  input logic                               out_last_of_segment,
  input logic                               out_end_of_batch
);
  import wlqe_pkg::*;

  a_batch_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_batch |-> out_last_of_segment)
    else $error("end of batch off the closing vertex");

  a_last_is_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_segment |-> out_tex_u == 1'b0 && out_tex_v == 2'd0)
    else $error("closing vertex is not on the first endpoint plus side");

  a_tex_v_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tex_v == 2'd0 || out_tex_v == 2'd2)
    else $error("bad tex_v");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vert_x))
    else $error("stalled vertex changed");

endmodule

bind wide_line_quad_expander wlqe_checker u_wlqe_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_vert_x          (out_vert_x),
  .out_tex_u           (out_tex_u),
  .out_tex_v           (out_tex_v),
  .out_last_of_segment (out_last_of_segment),
  .out_end_of_batch    (out_end_of_batch)
);
